>>> rtl/swa_pkg.sv
`timescale 1ns / 1ps

package swa_pkg;

    // Sizing of the pattern store and the alphabet.
    localparam int MAX_PAT    = 64;
    localparam int ALPHABET   = 26;

    // Fixed field widths of a beat.
    localparam int OP_W       = 2;
    localparam int LETTER_W   = 5;

    // Ring index, and a count that can hold MAX_PAT itself.
    localparam int PTR_W      = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
    localparam int CNT_W      = $clog2(MAX_PAT + 1);
    // Need counts range from -MAX_PAT to +MAX_PAT.
    localparam int NEED_W     = CNT_W + 1;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Operation codes of an input beat.
    localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // What the back end has to do with one item.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PAT_ADD,
        CMD_PAT_OVF,
        CMD_TEXT_EMPTY,
        CMD_TEXT,
        CMD_RESTART
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [LETTER_W-1:0]   letter;
        logic                  evict;
        logic [LETTER_W-1:0]   evict_letter;
    } cmd_t;

endpackage

>>> rtl/swa_in_if.sv
`timescale 1ns / 1ps

interface swa_in_if;
    import swa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output op, output letter, input ready);
    modport sink   (input valid, input op, input letter, output ready);
endinterface

>>> rtl/swa_out_if.sv
`timescale 1ns / 1ps

interface swa_out_if;
    logic valid;
    logic ready;
    logic window_match;
    logic found;
    logic pattern_overflow;

    modport source (output valid, output window_match, output found,
                    output pattern_overflow, input ready);
    modport sink   (input valid, input window_match, input found,
                    input pattern_overflow, output ready);
endinterface

>>> rtl/sliding_window_anagram_search.sv
// Result path: an accepted beat passes the front stage register, the queue and the
// back-end output register before its result beat is offered.
// Throughput: one item per cycle unless a stalled result port fills the queue; the ring
// read and counter update are pipelined, so a text letter can follow in the next cycle.
// Reset: rst_n is asynchronous and active low; it clears pattern length, window
// fill, ring pointer, need counts, the unmatched total and both sticky flags.
// The ring contents are not cleared; the window fill keeps stale entries unread.
`timescale 1ns / 1ps

module sliding_window_anagram_search (
    input  logic       clk,
    input  logic       rst_n,
    swa_in_if.sink     item,
    swa_out_if.source  result
);
    import swa_pkg::*;

    // The front end owns the pattern length, the window fill and the ring.
    // It classifies each beat into a command and, for a text letter that
    // pushes the oldest letter out of the window, reads that letter from the
    // ring in the same cycle as it writes the new one.
    logic  push_valid;
    logic  push_ready;
    cmd_t  push_cmd;

    // A short queue sits between the two halves so that a stalled result
    // port does not immediately stop input beats.
    logic  pop_valid;
    logic  pop_ready;
    cmd_t  pop_cmd;

    swa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    swa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // The back end keeps one need counter per letter and the count of letters
    // still unmatched. Every counter updates itself in parallel, so an
    // eviction and an insertion both land in the same cycle. Its output
    // register holds a finished result while the next command is processed.
    swa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .result    (result)
    );

endmodule

>>> rtl/swa_ram.sv
`timescale 1ns / 1ps

module swa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read and a write to the same entry return the old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/swa_front.sv
`timescale 1ns / 1ps

module swa_front (
    input  logic           clk,
    input  logic           rst_n,
    swa_in_if.sink         item,
    output logic           push_valid,
    input  logic           push_ready,
    output swa_pkg::cmd_t  push_cmd
);
    import swa_pkg::*;

    logic [CNT_W-1:0]    plen_reg, plen_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic                s1_valid_reg, s1_valid_next;
    cmd_t                s1_cmd_reg;
    cmd_t                cmd_next;
    logic                accept;
    logic                ring_wr;
    logic                ring_rd;
    logic [PTR_W-1:0]    evict_pos;
    logic [CNT_W-1:0]    ptr_ext;
    logic                letter_ok;
    logic [LETTER_W-1:0] ring_rd_data;

    assign item.ready = !s1_valid_reg || push_ready;
    assign accept     = item.valid && item.ready;
    assign letter_ok  = int'(item.letter) < ALPHABET;
    assign ptr_ext    = CNT_W'(ptr_reg);

    // Oldest window slot, pointer minus fill modulo the ring size.
    always_comb
    begin
        if (ptr_ext >= fill_reg)
        begin
            evict_pos = PTR_W'(ptr_ext - fill_reg);
        end
        else
        begin
            evict_pos = PTR_W'(ptr_ext + CNT_W'(MAX_PAT) - fill_reg);
        end
    end

    always_comb
    begin
        plen_next          = plen_reg;
        fill_next          = fill_reg;
        ptr_next           = ptr_reg;
        ring_wr            = 1'b0;
        ring_rd            = 1'b0;
        cmd_next.kind      = CMD_NOP;
        cmd_next.letter    = item.letter;
        cmd_next.evict     = 1'b0;
        cmd_next.evict_letter = '0;
        if (accept)
        begin
            unique case (item.op)
                OP_PATTERN:
                begin
                    if (plen_reg >= CNT_W'(MAX_PAT))
                    begin
                        cmd_next.kind = CMD_PAT_OVF;
                    end
                    else if (letter_ok)
                    begin
                        cmd_next.kind = CMD_PAT_ADD;
                        plen_next     = plen_reg + 1'b1;
                    end
                end
                OP_TEXT:
                begin
                    if (plen_reg == '0)
                    begin
                        cmd_next.kind = CMD_TEXT_EMPTY;
                    end
                    else
                    begin
                        cmd_next.kind  = CMD_TEXT;
                        ring_wr        = 1'b1;
                        cmd_next.evict = fill_reg >= plen_reg;
                        ring_rd        = fill_reg >= plen_reg;
                        if (fill_reg < plen_reg)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        if (ptr_reg == PTR_W'(MAX_PAT - 1))
                        begin
                            ptr_next = '0;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                end
                OP_RESTART:
                begin
                    cmd_next.kind = CMD_RESTART;
                    plen_next     = '0;
                    fill_next     = '0;
                    ptr_next      = '0;
                end
                default:
                begin
                    cmd_next.kind = CMD_NOP;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= '0;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg     <= plen_next;
            fill_reg     <= fill_next;
            ptr_reg      <= ptr_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd_next;
        end
    end

    swa_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (MAX_PAT)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (ptr_reg),
        .wr_data (item.letter),
        .rd_en   (ring_rd),
        .rd_addr (evict_pos),
        .rd_data (ring_rd_data)
    );

    // The evicted letter arrives from the ring's read register, beside its command in the stage register.
    always_comb
    begin
        push_cmd = s1_cmd_reg;
        if (s1_cmd_reg.evict)
        begin
            push_cmd.evict_letter = ring_rd_data;
        end
    end
    assign push_valid = s1_valid_reg;

    a_fill_le_plen: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= plen_reg)
        else $error("window fill exceeds pattern length");

    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !push_ready) |=> (s1_valid_reg && $stable(s1_cmd_reg)))
        else $error("front stage lost an item while the queue was full");

endmodule

>>> rtl/swa_fifo.sv
`timescale 1ns / 1ps

module swa_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  swa_pkg::cmd_t  push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output swa_pkg::cmd_t  pop_cmd
);
    import swa_pkg::*;

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != FIFO_CW'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/swa_back.sv
`timescale 1ns / 1ps

module swa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  swa_pkg::cmd_t  pop_cmd,
    swa_out_if.source      result
);
    import swa_pkg::*;

    logic signed [NEED_W-1:0] need_reg [ALPHABET];
    logic [CNT_W-1:0]         unmatched_reg, unmatched_next;
    logic                     found_flag_reg, found_flag_next;
    logic                     ovf_flag_reg, ovf_flag_next;
    logic                     res_valid_reg, res_valid_next;
    logic                     res_match_reg, res_found_reg, res_ovf_reg;
    logic                     match;
    logic                     pop;
    logic                     clear;
    logic [ALPHABET-1:0]      inc, dec, up, down;

    assign pop_ready = !res_valid_reg || result.ready;
    assign pop       = pop_valid && pop_ready;
    assign clear     = pop && (pop_cmd.kind == CMD_RESTART);

    // Each letter counter decides on its own whether it moves and whether its
    // sign change touches the unmatched total.
    always_comb
    begin
        for (int i = 0; i < ALPHABET; i++)
        begin
            inc[i] = pop && (((pop_cmd.kind == CMD_PAT_ADD) && (int'(pop_cmd.letter) == i))
                     || ((pop_cmd.kind == CMD_TEXT) && pop_cmd.evict
                         && (int'(pop_cmd.evict_letter) == i)));
            dec[i] = pop && (pop_cmd.kind == CMD_TEXT) && (int'(pop_cmd.letter) == i);
            up[i]   = inc[i] && !dec[i] && !need_reg[i][NEED_W-1];
            down[i] = dec[i] && !inc[i] && !need_reg[i][NEED_W-1] && (need_reg[i] != '0);
        end
    end

    always_comb
    begin
        unmatched_next  = unmatched_reg + CNT_W'(|up) - CNT_W'(|down);
        match           = 1'b0;
        found_flag_next = found_flag_reg;
        ovf_flag_next   = ovf_flag_reg;
        unique case (pop_cmd.kind)
            CMD_TEXT_EMPTY:
            begin
                match = 1'b1;
            end
            CMD_TEXT:
            begin
                match = unmatched_next == '0;
            end
            CMD_PAT_OVF:
            begin
                ovf_flag_next = 1'b1;
            end
            CMD_RESTART:
            begin
                unmatched_next = '0;
                ovf_flag_next  = 1'b0;
            end
            default:
            begin
                match = 1'b0;
            end
        endcase
        if (pop_cmd.kind == CMD_RESTART)
        begin
            found_flag_next = 1'b0;
        end
        else
        begin
            found_flag_next = found_flag_reg || match;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                need_reg[i] <= '0;
            end
            unmatched_reg  <= '0;
            found_flag_reg <= 1'b0;
            ovf_flag_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                unmatched_reg  <= unmatched_next;
                found_flag_reg <= found_flag_next;
                ovf_flag_reg   <= ovf_flag_next;
            end
            for (int i = 0; i < ALPHABET; i++)
            begin
                if (clear)
                begin
                    need_reg[i] <= '0;
                end
                else if (inc[i] && !dec[i])
                begin
                    need_reg[i] <= need_reg[i] + 1'b1;
                end
                else if (dec[i] && !inc[i])
                begin
                    need_reg[i] <= need_reg[i] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_match_reg <= match && !clear;
            res_found_reg <= found_flag_next;
            res_ovf_reg   <= ovf_flag_next;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.window_match     = res_match_reg;
    assign result.found            = res_found_reg;
    assign result.pattern_overflow = res_ovf_reg;

    a_match_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_match_reg) |-> res_found_reg)
        else $error("a matching window did not report found");

    a_found_from_text: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_flag_reg) |->
            $past(pop && ((pop_cmd.kind == CMD_TEXT) || (pop_cmd.kind == CMD_TEXT_EMPTY))))
        else $error("found flag set by an item that is not a text letter");

endmodule
